// ===== design/tilt_pkg.sv =====
`default_nettype none

package tilt_pkg;

  localparam int IN_W     = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 32;
  localparam int PAD_W    = 16;
  localparam int ROOT_W   = 24;
  localparam int REM_W    = 26;
  localparam int CW       = 34;
  localparam int ZW       = 25;
  localparam int NITER    = 20;
  localparam int TFRAC    = 16;
  localparam int PRESHIFT = 6;
  localparam int YSHIFT   = 14;
  localparam int OUT_W    = 16;
  localparam int NLANE    = 2;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic signed [ZW-1:0] ATAN_TAB [NITER] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
    25'sd117304,  25'sd58666,   25'sd29335,  25'sd14668,  25'sd7334,
    25'sd3667,    25'sd1833,    25'sd917,    25'sd458,    25'sd229,
    25'sd115,     25'sd57,      25'sd29,     25'sd14,     25'sd7
  };

  typedef struct packed {
    logic [SUM_W-1:0]       sum;
    logic signed [IN_W-1:0] num;
    logic [ROOT_W-1:0]      root;
    logic [REM_W-1:0]       rem;
    logic                   zf;
  } sqrt_stg_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zf;
  } cordic_stg_t;

endpackage

`default_nettype wire

// ===== design/accel_tilt_angles_top.sv =====
// Throughput: one word per cycle unless the output stalls; 1 square stage,
// 1 sum stage, 24 square-root digit stages, 20 CORDIC stages, 1 round/clamp
// stage and the output register.
// A stall on the output freezes every stage together; in_ready follows it.
// Reset clears the valid bits only; the datapath registers are not reset.
`default_nettype none

module accel_tilt_angles_top #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [tilt_pkg::IN_W-1:0]   in_accel_x,
  input  logic signed [tilt_pkg::IN_W-1:0]   in_accel_y,
  input  logic signed [tilt_pkg::IN_W-1:0]   in_accel_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [tilt_pkg::OUT_W-1:0]  out_roll_angle,
  output logic signed [tilt_pkg::OUT_W-1:0]  out_pitch_angle
);

  localparam int IN_W     = tilt_pkg::IN_W;
  localparam int SQ_W     = tilt_pkg::SQ_W;
  localparam int SUM_W    = tilt_pkg::SUM_W;
  localparam int PAD_W    = tilt_pkg::PAD_W;
  localparam int ROOT_W   = tilt_pkg::ROOT_W;
  localparam int REM_W    = tilt_pkg::REM_W;
  localparam int RS_W     = REM_W + 2;
  localparam int RAD_W    = SUM_W + PAD_W;
  localparam int CW       = tilt_pkg::CW;
  localparam int ZW       = tilt_pkg::ZW;
  localparam int NITER    = tilt_pkg::NITER;
  localparam int NLANE    = tilt_pkg::NLANE;
  localparam int OUT_W    = tilt_pkg::OUT_W;
  localparam int PRESHIFT = tilt_pkg::PRESHIFT;
  localparam int YSHIFT   = tilt_pkg::YSHIFT;
  localparam int SQ_STG   = ROOT_W;
  localparam int NSTG     = 2 + SQ_STG + NITER + 2;
  localparam int RSH      = tilt_pkg::TFRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ZW-1:0] RND     = ZW'(1 << (RSH - 1));
  localparam logic signed [ZW-1:0] LIM     = ZW'(90 << ANGLE_FRAC_BITS);
  localparam logic signed [ZW-1:0] OUT_MAX = ZW'(32767);
  localparam logic signed [ZW-1:0] OUT_MIN = ZW'(-32768);

  logic             adv;
  logic [NSTG-1:0]  v_r;

  // whole pipe moves when the output register is empty or being taken
  assign adv       = !v_r[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // squares
  logic signed [2*IN_W-1:0] px, py, pz;
  logic [SQ_W-1:0]          sqx_r, sqy_r, sqz_r;
  logic signed [IN_W-1:0]   ax_r, ay_r;

  assign px = in_accel_x * in_accel_x;
  assign py = in_accel_y * in_accel_y;
  assign pz = in_accel_z * in_accel_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r <= px[SQ_W-1:0];
      sqy_r <= py[SQ_W-1:0];
      sqz_r <= pz[SQ_W-1:0];
      ax_r  <= in_accel_x;
      ay_r  <= in_accel_y;
    end
  end

  // sums of squares, numerators, both-zero flag
  tilt_pkg::sqrt_stg_t sb_nxt [NLANE];
  tilt_pkg::sqrt_stg_t sb_r   [NLANE];

  always_comb begin
    sb_nxt[tilt_pkg::LANE_ROLL].sum   = SUM_W'(sqx_r) + SUM_W'(sqz_r);
    sb_nxt[tilt_pkg::LANE_ROLL].num   = ay_r;
    sb_nxt[tilt_pkg::LANE_PITCH].sum  = SUM_W'(sqy_r) + SUM_W'(sqz_r);
    sb_nxt[tilt_pkg::LANE_PITCH].num  = ax_r;
    for (int l = 0; l < NLANE; l++) begin
      sb_nxt[l].root = '0;
      sb_nxt[l].rem  = '0;
      sb_nxt[l].zf   = (sb_nxt[l].sum == '0) && (sb_nxt[l].num == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r <= sb_nxt;
    end
  end

  // square root of sum * 2^16, one result bit per stage
  tilt_pkg::sqrt_stg_t sq_r [SQ_STG][NLANE];

  for (genvar k = 0; k < SQ_STG; k++) begin : g_sqrt
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      tilt_pkg::sqrt_stg_t sin;
      tilt_pkg::sqrt_stg_t sq_nxt;

      if (k == 0) begin : g_first
        assign sin = sb_r[l];
      end else begin : g_next
        assign sin = sq_r[k-1][l];
      end

      always_comb begin
        logic [RAD_W-1:0] rad;
        logic [RS_W-1:0]  rs;
        logic [RS_W-1:0]  trial;
        rad    = {sin.sum, {PAD_W{1'b0}}};
        rs     = {sin.rem, rad[2*(SQ_STG-1-k)+1 -: 2]};
        trial  = RS_W'({sin.root, 2'b01});
        sq_nxt = sin;
        if (rs >= trial) begin
          sq_nxt.rem  = REM_W'(rs - trial);
          sq_nxt.root = {sin.root[ROOT_W-2:0], 1'b1};
        end else begin
          sq_nxt.rem  = rs[REM_W-1:0];
          sq_nxt.root = {sin.root[ROOT_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          sq_r[k][l] <= sq_nxt;
        end
      end
    end
  end

  // CORDIC vectoring, one rotation per stage
  tilt_pkg::cordic_stg_t cd_r [NITER][NLANE];

  for (genvar i = 0; i < NITER; i++) begin : g_cordic
    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      tilt_pkg::cordic_stg_t cin;
      tilt_pkg::cordic_stg_t cd_nxt;

      if (i == 0) begin : g_first
        always_comb begin
          cin.x  = CW'({sq_r[SQ_STG-1][l].root, {PRESHIFT{1'b0}}});
          cin.y  = {{(CW-IN_W-YSHIFT){sq_r[SQ_STG-1][l].num[IN_W-1]}},
                    sq_r[SQ_STG-1][l].num, {YSHIFT{1'b0}}};
          cin.z  = '0;
          cin.zf = sq_r[SQ_STG-1][l].zf;
        end
      end else begin : g_next
        assign cin = cd_r[i-1][l];
      end

      always_comb begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        xs        = cin.x >>> i;
        ys        = cin.y >>> i;
        cd_nxt.zf = cin.zf;
        if (!cin.y[CW-1]) begin
          cd_nxt.x = cin.x + ys;
          cd_nxt.y = cin.y - xs;
          cd_nxt.z = cin.z + tilt_pkg::ATAN_TAB[i];
        end else begin
          cd_nxt.x = cin.x - ys;
          cd_nxt.y = cin.y + xs;
          cd_nxt.z = cin.z - tilt_pkg::ATAN_TAB[i];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          cd_r[i][l] <= cd_nxt;
        end
      end
    end
  end

  // round to output fraction, clamp to +/-90, zero if both-zero flag, negate pitch
  logic signed [ZW-1:0] ang_nxt [NLANE];
  logic signed [ZW-1:0] ang_r   [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      logic signed [ZW-1:0] zr;
      logic signed [ZW-1:0] a;
      zr = cd_r[NITER-1][l].z + RND;
      a  = zr >>> RSH;
      if (a > LIM) begin
        a = LIM;
      end else if (a < -LIM) begin
        a = -LIM;
      end
      if (cd_r[NITER-1][l].zf) begin
        a = '0;
      end
      if (l == tilt_pkg::LANE_PITCH) begin
        a = -a;
      end
      ang_nxt[l] = a;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r <= ang_nxt;
    end
  end

  // saturate to the output width
  logic signed [OUT_W-1:0] out_nxt [NLANE];
  logic signed [OUT_W-1:0] out_r   [NLANE];

  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      if (ang_r[l] > OUT_MAX) begin
        out_nxt[l] = OUT_MAX[OUT_W-1:0];
      end else if (ang_r[l] < OUT_MIN) begin
        out_nxt[l] = OUT_MIN[OUT_W-1:0];
      end else begin
        out_nxt[l] = ang_r[l][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_roll_angle  = out_r[tilt_pkg::LANE_ROLL];
  assign out_pitch_angle = out_r[tilt_pkg::LANE_PITCH];

endmodule

`default_nettype wire
